>>> hdl/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// shared constants for the trial division prime test core
// ----------------------------------------------------------------------------
package tdp_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // first trial divisor; after it only odd divisors are tried
    localparam int FIRST_DIVISOR = 2;

endpackage

>>> hdl/tdp_serial_div.sv
// ----------------------------------------------------------------------------
// tdp_serial_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdp_serial_div #(
    parameter int WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    // one restoring step: bring down the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = ~diff[WIDTH];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(WIDTH);
            run_next = 1'b1;
        end else if (run_reg) begin
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/trial_division_prime_test_core.sv
// sequence: negatives, zero and one go straight to the finish state; otherwise each trial
// divisor takes a launch, DATA_WIDTH serial divide steps in the bit-serial divider and a
// check, and the finish state posts the result once the output slot is free
// throughput: one value at a time; the worst case, a prime near 2^31, is about
// 23000 divisors at DATA_WIDTH = 32
// reset: synchronous active-low aresetn clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// tests one signed value for primality by trial division, one divisor at a time
// ----------------------------------------------------------------------------
module trial_division_prime_test_core #(
    parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_prime
);

    import tdp_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [DATA_WIDTH-1:0] div_reg, div_next;
    logic                  res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_is_prime_reg, m_is_prime_next;

    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_quo;
    logic [DATA_WIDTH-1:0] div_rem;
    logic [DATA_WIDTH-1:0] in_bits;

    assign in_bits = $unsigned(s_value);
    assign s_ready = (state_reg == ST_IDLE);

    tdp_serial_div #(
        .WIDTH (DATA_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == ST_LAUNCH),
        .dividend  (value_reg),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next      = state_reg;
        value_next      = value_reg;
        div_next        = div_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_is_prime_next = m_is_prime_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = in_bits;
                    div_next   = DATA_WIDTH'(FIRST_DIVISOR);
                    // negatives, zero and one are never prime
                    if (in_bits[DATA_WIDTH-1] || (in_bits < DATA_WIDTH'(2))) begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    // divisor past the square root once it exceeds the quotient
                    if (div_reg > div_quo) begin
                        res_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (div_rem == '0) begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        div_next   = (div_reg == DATA_WIDTH'(FIRST_DIVISOR)) ?
                                     DATA_WIDTH'(3) : div_reg + DATA_WIDTH'(2);
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_is_prime_next = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg      <= value_next;
        div_reg        <= div_next;
        res_reg        <= res_next;
        m_is_prime_reg <= m_is_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

endmodule

>>> verif/trial_division_prime_test_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_core_test
// self-checking bench: drives signed values through the valid/ready input,
// predicts primality by trial division and checks every result beat in order
// ----------------------------------------------------------------------------
module trial_division_prime_test_core_test;

    import tdp_pkg::*;

    localparam int DATA_WIDTH     = DATA_WIDTH_DEF;
    localparam int IDLE_LIMIT     = 2500000;
    localparam int DRAIN_CYCLES   = 4 * (DATA_WIDTH + 2);
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PER_RUN = 20;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        bit                           is_prime;
    } prime_answer_t;

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_value    = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic                         m_is_prime;

    prime_answer_t answers_q[$];
    prime_answer_t oldest_answer;
    int            failures       = 0;
    int            quiet_cycles   = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    trial_division_prime_test_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_is_prime(m_is_prime)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bit prime_by_trial_division(input logic signed [DATA_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned divisor;
        if (value < 2) return 1'b0;
        n = value;
        divisor = FIRST_DIVISOR;
        // stop once divisor squared passes the value
        while (divisor <= n / divisor) begin
            if (n % divisor == 0) return 1'b0;
            divisor = (divisor == FIRST_DIVISOR) ? FIRST_DIVISOR + 1 : divisor + 2;
        end
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // inputs are stable between rising edges, so sample handshakes mid-cycle
    always @(negedge aclk) begin
        if (aresetn && s_valid && s_ready)
            answers_q.push_back('{s_value, prime_by_trial_division(s_value)});
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answers_q.size() == 0) begin
                note_failure($sformatf("result beat is_prime=%0b with nothing outstanding",
                                       m_is_prime));
            end else begin
                oldest_answer = answers_q.pop_front();
                if (m_is_prime !== oldest_answer.is_prime)
                    note_failure($sformatf("value %0d: expected is_prime=%0b, got %0b",
                                           oldest_answer.value, oldest_answer.is_prime,
                                           m_is_prime));
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** trial_division_prime_test_core: FAILED **");
            $finish;
        end
    end

    // called and returns at a rising edge; the value is accepted at the return edge
    task automatic send_value(input logic signed [DATA_WIDTH-1:0] value);
        bit accepted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do begin
            @(negedge aclk);
            accepted = s_ready;
            @(posedge aclk);
        end while (!accepted);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] random_value();
        int unsigned pick;
        logic [DATA_WIDTH-1:0] wide;
        pick = $urandom_range(99);
        wide = DATA_WIDTH'($urandom) >> 1;
        if (pick < 35) return $urandom_range(4095);
        if (pick < 50) return $urandom_range(65535);
        if (pick < 65) return {1'b1, wide[DATA_WIDTH-2:0]};
        // wide positive multiple of fifteen keeps the search short
        if (pick < 85) return wide - (wide % 15);
        return $urandom_range(255, 2) * $urandom_range(255, 2);
    endfunction

    task automatic run_random_values(input int count);
        repeat (count) send_value(random_value());
    endtask

    task automatic test_special_values();
        send_value({1'b1, {(DATA_WIDTH-1){1'b0}}});
        send_value(-1);
        send_value(-7);
        send_value(0);
        send_value(1);
        send_value(2);
        send_value(3);
        send_value({1'b0, {(DATA_WIDTH-1){1'b1}}});
        send_value({1'b0, {(DATA_WIDTH-2){1'b1}}, 1'b0});
    endtask

    task automatic test_known_primes_and_composites();
        // squares of primes sit right on the search bound; other primes and composites follow
        send_value(4);
        send_value(9);
        send_value(25);
        send_value(49);
        send_value(121);
        send_value(63001);
        send_value(5);
        send_value(97);
        send_value(91);
        send_value(65521);
        send_value(1 << (DATA_WIDTH - 2));
        send_value(2147483645);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_values(RANDOM_PER_RUN);
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        run_random_values(RANDOM_PER_RUN);
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_random_values(RANDOM_PER_RUN);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        run_random_values(RANDOM_PER_RUN);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_values();
        test_known_primes_and_composites();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        s_valid <= 1'b0;

        while (answers_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("** trial_division_prime_test_core: PASSED **");
        end else begin
            $display("** trial_division_prime_test_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/tdp_pkg.sv
hdl/tdp_serial_div.sv
hdl/trial_division_prime_test_core.sv
verif/trial_division_prime_test_core_test.sv
